// ===== src/i2csrf_pkg.sv =====
// shared types, constants and codes for the i2c slave register file
// no dependencies
`default_nettype none

package i2csrf_pkg;

   localparam int NVRAM_BYTES_DEFAULT = 256;
   localparam int NVRAM_BYTES_MAX     = 4096;
   localparam int NV_ADDR_W           = $clog2(NVRAM_BYTES_MAX);

   localparam int REG_COUNT = 64;
   localparam int REG_AW    = $clog2(REG_COUNT);

   localparam logic [7:0] RW_START       = 8'd16;
   localparam logic [7:0] STATUS_INDEX   = 8'd2;
   localparam logic [7:0] TIME_LOW_INDEX = 8'd31;
   localparam logic [7:0] PRESS_MASK     = 8'h01;

   localparam logic [7:0] ADDR_MATCH_MASK = 8'hFE;
   localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd36;
   localparam logic [7:0] ADDRESS_MASK_RESET  = 8'd254;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // register indexes
   localparam logic CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic CSR_ADDRESS_MASK  = 1'b1;

   // event modes
   localparam logic [2:0] MODE_START  = 3'd0;
   localparam logic [2:0] MODE_DATA   = 3'd1;
   localparam logic [2:0] MODE_SENT   = 3'd2;
   localparam logic [2:0] MODE_STOP   = 3'd3;
   localparam logic [2:0] MODE_ERROR  = 3'd4;
   localparam logic [2:0] MODE_LWRITE = 3'd5;
   localparam logic [2:0] MODE_LREAD  = 3'd6;

   // store operations
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_NV_RD = 3'd1;
   localparam logic [2:0] OP_NV_WR = 3'd2;
   localparam logic [2:0] OP_RG_RD = 3'd3;
   localparam logic [2:0] OP_RG_WR = 3'd4;
   localparam logic [2:0] OP_LC_RD = 3'd5;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] bus_byte;
      logic       master_ack;
      logic [5:0] local_index;
      logic [7:0] local_value;
   } req_word_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       ack_out;
      logic       time_trigger;
      logic [7:0] local_data;
      logic       busy_res;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]           op;
      logic [NV_ADDR_W-1:0] addr;
      logic [7:0]           data;
      logic                 clr;
      logic                 ack;
      logic                 trig;
      logic                 busy;
   } cmd_type;

endpackage

`default_nettype wire

// ===== src/i2csrf_front.sv =====
// front end: config registers, address match, pointer and phase tracking
// turns each accepted word into a store command; depends on i2csrf_pkg
`default_nettype none

module i2csrf_front
   import i2csrf_pkg::*;
#(
   parameter int NVRAM_BYTES = NVRAM_BYTES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   input  wire logic         csr_write,
   input  wire logic         csr_index,
   input  wire logic [7:0]   csr_data,
   input  wire logic         q_full,
   input  wire logic         clr_busy,
   output logic              cmd_push,
   output cmd_type           cmd_word
);

   logic [7:0]  slave_address_ff, slave_address_in;
   logic [7:0]  address_mask_ff, address_mask_in;
   logic [15:0] ptr_ff, ptr_in;
   logic [1:0]  phase_ff, phase_in;
   logic        active_ff, active_in;
   logic        accept;
   logic        in_nv;
   logic [REG_AW-1:0] reg_idx;
   cmd_type     rd_cmd, wr_cmd, cmd;

   assign req_ready = !q_full && !clr_busy;
   assign accept    = req_valid && req_ready;
   assign in_nv     = ({1'b0, ptr_ff} < 17'(NVRAM_BYTES));
   assign reg_idx   = ptr_ff[REG_AW-1:0];

   always_comb begin
      slave_address_in = slave_address_ff;
      address_mask_in  = address_mask_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SLAVE_ADDRESS: slave_address_in = csr_data;
            CSR_ADDRESS_MASK:  address_mask_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rd_cmd = '0;
      wr_cmd = '0;
      if (in_nv) begin
         rd_cmd.op   = OP_NV_RD;
         rd_cmd.addr = ptr_ff[NV_ADDR_W-1:0];
         wr_cmd.op   = OP_NV_WR;
         wr_cmd.addr = ptr_ff[NV_ADDR_W-1:0];
      end else begin
         rd_cmd.op   = OP_RG_RD;
         rd_cmd.addr = NV_ADDR_W'(reg_idx);
         rd_cmd.clr  = ({2'b00, reg_idx} == STATUS_INDEX);
         wr_cmd.addr = NV_ADDR_W'(reg_idx);
         if ({2'b00, reg_idx} >= RW_START) begin
            wr_cmd.op   = OP_RG_WR;
            wr_cmd.trig = ({2'b00, reg_idx} == TIME_LOW_INDEX);
         end
      end
      wr_cmd.data = req_word.bus_byte;
   end

   always_comb begin
      ptr_in    = ptr_ff;
      phase_in  = phase_ff;
      active_in = active_ff;
      cmd       = '0;
      case (req_word.mode)
         MODE_START: begin
            active_in = 1'b1;
            if ((req_word.bus_byte & address_mask_ff & ADDR_MATCH_MASK) ==
                (slave_address_ff & address_mask_ff & ADDR_MATCH_MASK)) begin
               phase_in = 2'd0;
               if ((req_word.bus_byte & ADDR_READ_BIT) != 8'h00) begin
                  cmd    = rd_cmd;
                  ptr_in = ptr_ff + 16'd1;
               end else begin
                  cmd.ack = 1'b1;
               end
            end
         end
         MODE_DATA: begin
            active_in = 1'b1;
            case (phase_ff)
               2'd0: begin
                  ptr_in   = {8'h00, req_word.bus_byte};
                  phase_in = 2'd1;
               end
               2'd1: begin
                  ptr_in   = {ptr_ff[7:0], req_word.bus_byte};
                  phase_in = 2'd2;
               end
               default: begin
                  cmd    = wr_cmd;
                  ptr_in = ptr_ff + 16'd1;
               end
            endcase
            cmd.ack = 1'b1;
         end
         MODE_SENT: begin
            active_in = 1'b1;
            if (req_word.master_ack) begin
               cmd    = rd_cmd;
               ptr_in = ptr_ff + 16'd1;
            end
         end
         MODE_STOP: active_in = 1'b0;
         MODE_LWRITE: begin
            cmd.op   = OP_RG_WR;
            cmd.addr = NV_ADDR_W'(req_word.local_index);
            cmd.data = req_word.local_value;
         end
         MODE_LREAD: begin
            cmd.op   = OP_LC_RD;
            cmd.addr = NV_ADDR_W'(req_word.local_index);
         end
         default: active_in = 1'b0;
      endcase
      cmd.busy = active_in;
   end

   assign cmd_push = accept;
   assign cmd_word = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_ADDRESS_RESET;
         address_mask_ff  <= ADDRESS_MASK_RESET;
         ptr_ff           <= '0;
         phase_ff         <= '0;
         active_ff        <= 1'b0;
      end else begin
         slave_address_ff <= slave_address_in;
         address_mask_ff  <= address_mask_in;
         if (accept) begin
            ptr_ff    <= ptr_in;
            phase_ff  <= phase_in;
            active_ff <= active_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/i2csrf_queue.sv =====
// short command queue between front end and store back end
// depends on i2csrf_pkg
`default_nettype none

module i2csrf_queue
   import i2csrf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_word,
   input  wire logic    pop,
   output cmd_type      head_word,
   output logic         full,
   output logic         empty
);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_word = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + (QUEUE_AW+1)'(1);
      else if (pop && !push) count_in = count_ff - (QUEUE_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/i2csrf_back.sv =====
// back end: byte store and register store memories, clearing pass,
// command execution and the result register; depends on i2csrf_pkg
`default_nettype none

module i2csrf_back
   import i2csrf_pkg::*;
#(
   parameter int NVRAM_BYTES = NVRAM_BYTES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire cmd_type q_head,
   output logic         q_pop,
   output logic         clr_busy,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int NV_DEPTH = (NVRAM_BYTES > 0) ? NVRAM_BYTES : 1;
   localparam int NV_AW    = (NV_DEPTH > 1) ? $clog2(NV_DEPTH) : 1;
   localparam int CLR_LEN  = (NV_DEPTH > REG_COUNT) ? NV_DEPTH : REG_COUNT;
   localparam int CLR_W    = $clog2(CLR_LEN);

   logic [7:0] nv_mem [NV_DEPTH];
   logic [7:0] rg_mem [REG_COUNT];

   logic [7:0]        nv_rd_ff, rg_rd_ff;
   logic              nv_we, nv_re, rg_we, rg_re;
   logic [NV_AW-1:0]  nv_addr;
   logic [REG_AW-1:0] rg_addr;
   logic [7:0]        nv_wdata, rg_wdata;

   logic             clr_busy_ff;
   logic [CLR_W-1:0] clr_cnt_ff;
   logic             pend_valid_ff, pend_valid_in;
   cmd_type          pend_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff, rsp_in;
   logic             pop, complete;

   assign pop      = !clr_busy_ff && !q_empty && !pend_valid_ff;
   assign complete = pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      nv_we    = 1'b0;
      nv_re    = 1'b0;
      rg_we    = 1'b0;
      rg_re    = 1'b0;
      nv_addr  = q_head.addr[NV_AW-1:0];
      rg_addr  = q_head.addr[REG_AW-1:0];
      nv_wdata = q_head.data;
      rg_wdata = q_head.data;
      if (clr_busy_ff) begin
         nv_we    = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(NV_DEPTH));
         rg_we    = ({1'b0, clr_cnt_ff} < (CLR_W+1)'(REG_COUNT));
         nv_addr  = clr_cnt_ff[NV_AW-1:0];
         rg_addr  = clr_cnt_ff[REG_AW-1:0];
         nv_wdata = 8'h00;
         rg_wdata = 8'h00;
      end else if (complete && pend_ff.op == OP_RG_RD && pend_ff.clr) begin
         rg_we    = 1'b1;
         rg_addr  = pend_ff.addr[REG_AW-1:0];
         rg_wdata = rg_rd_ff & ~PRESS_MASK;
      end else if (pop) begin
         case (q_head.op)
            OP_NV_RD: nv_re = 1'b1;
            OP_NV_WR: nv_we = 1'b1;
            OP_RG_RD: rg_re = 1'b1;
            OP_RG_WR: rg_we = 1'b1;
            OP_LC_RD: rg_re = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (nv_we) nv_mem[nv_addr] <= nv_wdata;
      if (nv_re) nv_rd_ff <= nv_mem[nv_addr];
   end

   always_ff @(posedge clock) begin
      if (rg_we) rg_mem[rg_addr] <= rg_wdata;
      if (rg_re) rg_rd_ff <= rg_mem[rg_addr];
   end

   always_comb begin
      rsp_in              = '0;
      rsp_in.ack_out      = pend_ff.ack;
      rsp_in.time_trigger = pend_ff.trig;
      rsp_in.busy_res     = pend_ff.busy;
      case (pend_ff.op)
         OP_NV_RD: begin
            rsp_in.tx_byte  = nv_rd_ff;
            rsp_in.tx_valid = 1'b1;
         end
         OP_RG_RD: begin
            rsp_in.tx_byte  = rg_rd_ff;
            rsp_in.tx_valid = 1'b1;
         end
         OP_LC_RD: rsp_in.local_data = rg_rd_ff;
         default: ;
      endcase
   end

   assign pend_valid_in = pop || (pend_valid_ff && !complete);
   assign rsp_valid_in  = complete || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (pop) pend_ff <= q_head;
      if (complete) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff   <= 1'b1;
         clr_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
            if (clr_cnt_ff == CLR_W'(CLR_LEN - 1)) clr_busy_ff <= 1'b0;
         end
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign q_pop     = pop;
   assign clr_busy  = clr_busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTH
   a_clear_queue_empty: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> q_empty)
      else $error("command queued during clearing pass");

   a_pop_pends: assert property (@(posedge clock) disable iff (reset)
      pop |=> pend_valid_ff)
      else $error("popped command not pending");

   a_rsp_from_pend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_valid_ff))
      else $error("result without pending command");

   a_tx_no_local: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tx_valid) |-> (rsp_ff.local_data == 8'h00))
      else $error("bus read result carries local data");
`endif

endmodule

`default_nettype wire

// ===== src/i2c_slave_register_file_core.sv =====
// i2c slave register file, top level: front end, command queue, back end
// depends on i2csrf_pkg, i2csrf_front, i2csrf_queue, i2csrf_back
//
// usage:
//   req channel (valid/ready) carries one decoded bus event or local access
//   per word; rsp channel (valid/ready) returns exactly one result word per
//   request word, in order. csr_write/csr_index/csr_data write slave_address
//   (index 0) and address_mask (index 1) with no handshake.
//   path: each request word passes through the queue, the pending command and
//   memory read registers, and the result register. the back end takes the
//   next command only once it has completed the current one, since it waits
//   on the registered read of the byte and register store memories.
//   reset: synchronous; a clearing pass then zeroes both stores, with
//   req_ready low until the pass ends.
//   stall: while rsp_ready is low the result is held, the back end stops and
//   the front end keeps taking words until the two-entry queue is full.
`default_nettype none

module i2c_slave_register_file_core
   import i2csrf_pkg::*;
#(
   parameter int NVRAM_BYTES = NVRAM_BYTES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_write,
   input  wire logic         csr_index,
   input  wire logic [7:0]   csr_data
);

   logic    q_full, q_empty, q_pop, cmd_push, clr_busy;
   cmd_type cmd_word, q_head;

   i2csrf_front #(.NVRAM_BYTES(NVRAM_BYTES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .clr_busy  (clr_busy),
      .cmd_push  (cmd_push),
      .cmd_word  (cmd_word)
   );

   i2csrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_word (cmd_word),
      .pop       (q_pop),
      .head_word (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   i2csrf_back #(.NVRAM_BYTES(NVRAM_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .clr_busy  (clr_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
